>>> sv/olw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olw_pkg
// Shared types and constants for the ordered list unit.
// ----------------------------------------------------------------------------
package olw_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_PREPEND = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_WALK    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_LOAD = 3'd1,
    OP_PUSH = 3'd2,
    OP_ROT  = 3'd3,
    OP_DROP = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     is_load;
    logic     is_tail;
  } cell_ctl_t;

endpackage

>>> sv/olw_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olw_cell
// One list slot: holds a value, loads a new one, or takes one from a neighbor or the head on shifts.
// ----------------------------------------------------------------------------
module olw_cell (
  input  logic                             clk_i,
  input  olw_pkg::cell_ctl_t               ctl_i,
  input  logic signed [olw_pkg::DATA_W-1:0] value_i,
  input  logic signed [olw_pkg::DATA_W-1:0] left_i,
  input  logic signed [olw_pkg::DATA_W-1:0] right_i,
  input  logic signed [olw_pkg::DATA_W-1:0] head_i,
  output logic signed [olw_pkg::DATA_W-1:0] data_o
);

  logic signed [olw_pkg::DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      olw_pkg::OP_HOLD: data_d = data_q;
      olw_pkg::OP_LOAD: if (ctl_i.is_load) data_d = value_i;
      olw_pkg::OP_PUSH: data_d = left_i;
      olw_pkg::OP_ROT:  data_d = ctl_i.is_tail ? head_i : right_i;
      olw_pkg::OP_DROP: data_d = right_i;
      default:          data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> sv/olw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olw_ctrl
// Command sequencer, fill count and result register for the cell row.
// ----------------------------------------------------------------------------
module olw_ctrl #(
  parameter int CAPACITY = olw_pkg::CAPACITY_DEF,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [olw_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [olw_pkg::DATA_W-1:0] item_o,
  output logic                              last_o,
  input  logic signed [olw_pkg::DATA_W-1:0] head_i,
  output olw_pkg::cell_op_e                 op_o,
  output logic [IW-1:0]                     load_idx_o,
  output logic [IW-1:0]                     tail_idx_o,
  output logic signed [olw_pkg::DATA_W-1:0] value_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_WALK
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, rem_q, rem_d;
  logic found_q, found_d, empty_q, empty_d;
  olw_pkg::cmd_e cmd_q, cmd_d;
  logic signed [olw_pkg::DATA_W-1:0] value_q, value_d;
  logic out_valid_q, out_valid_d, last_q, last_d;
  logic [1:0] status_q, status_d;
  logic signed [olw_pkg::DATA_W-1:0] item_q, item_d;
  logic out_free, emit;
  logic [CW-1:0] tail_cnt;

  assign out_free = !out_valid_q || !out_stall_i;
  assign tail_cnt = count_q - CW'(1);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rem_d    = rem_q;
    found_d  = found_q;
    empty_d  = empty_q;
    cmd_d    = cmd_q;
    value_d  = value_q;
    status_d = status_q;
    item_d   = item_q;
    last_d   = last_q;
    emit     = 1'b0;
    op_o     = olw_pkg::OP_HOLD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = olw_pkg::cmd_e'(cmd_i);
          value_d = value_i;
          rem_d   = count_q;
          found_d = 1'b0;
          empty_d = (count_q == '0);
          case (olw_pkg::cmd_e'(cmd_i))
            olw_pkg::CMD_DELETE: state_d = S_DEL;
            olw_pkg::CMD_WALK:   state_d = S_WALK;
            default:             state_d = S_INS;
          endcase
        end
      end
      S_INS: begin
        if (out_free) begin
          emit     = 1'b1;
          item_d   = '0;
          last_d   = 1'b1;
          state_d  = S_IDLE;
          if (count_q == CW'(CAPACITY)) begin
            status_d = olw_pkg::ST_FULL;
          end else begin
            status_d = olw_pkg::ST_OK;
            count_d  = count_q + CW'(1);
            op_o     = (cmd_q == olw_pkg::CMD_APPEND) ? olw_pkg::OP_LOAD : olw_pkg::OP_PUSH;
          end
        end
      end
      S_DEL: begin
        if (out_free) begin
          if (rem_q == '0) begin
            emit    = 1'b1;
            item_d  = '0;
            last_d  = 1'b1;
            state_d = S_IDLE;
            if (empty_q) status_d = olw_pkg::ST_EMPTY;
            else if (found_q) status_d = olw_pkg::ST_OK;
            else status_d = olw_pkg::ST_NOT_FOUND;
          end else begin
            rem_d = rem_q - CW'(1);
            if (!found_q && head_i == value_q) begin
              op_o    = olw_pkg::OP_DROP;
              found_d = 1'b1;
              count_d = count_q - CW'(1);
            end else begin
              op_o = olw_pkg::OP_ROT;
            end
          end
        end
      end
      S_WALK: begin
        if (out_free) begin
          emit = 1'b1;
          if (empty_q) begin
            status_d = olw_pkg::ST_EMPTY;
            item_d   = '0;
            last_d   = 1'b1;
            state_d  = S_IDLE;
          end else begin
            status_d = olw_pkg::ST_OK;
            item_d   = head_i;
            last_d   = (rem_q == CW'(1));
            op_o     = olw_pkg::OP_ROT;
            rem_d    = rem_q - CW'(1);
            if (rem_q == CW'(1)) state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (emit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      found_q     <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      found_q     <= found_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    value_q  <= value_d;
    status_q <= status_d;
    item_q   <= item_d;
    last_q   <= last_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign item_o      = item_q;
  assign last_o      = last_q;
  assign load_idx_o  = count_q[IW-1:0];
  assign tail_idx_o  = tail_cnt[IW-1:0];
  assign value_o     = value_q;

endmodule

>>> sv/ordered_list_insert_delete_walk_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_walk_unit
// Bounded ordered list of signed values with append, prepend, delete, walk.
// ----------------------------------------------------------------------------
// One command at a time. Append and prepend are accepted, then do the write
// and give the status beat. Delete and walk rotate the row of cells one place
// per cycle, once per stored entry, so the list is back in order when done;
// walk gives one beat per entry, head first, or a single beat on an empty
// list. A stalled result beat pauses the rotation.
module ordered_list_insert_delete_walk_unit #(
  parameter int CAPACITY = olw_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [olw_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [olw_pkg::DATA_W-1:0] item_o,
  output logic                              last_o
);

  localparam int IW = $clog2(CAPACITY);

  olw_pkg::cell_op_e op;
  logic [IW-1:0] load_idx, tail_idx;
  logic signed [olw_pkg::DATA_W-1:0] new_value;
  logic signed [olw_pkg::DATA_W-1:0] cell_data [CAPACITY];
  olw_pkg::cell_ctl_t cell_ctl [CAPACITY];

  olw_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .item_o     (item_o),
    .last_o     (last_o),
    .head_i     (cell_data[0]),
    .op_o       (op),
    .load_idx_o (load_idx),
    .tail_idx_o (tail_idx),
    .value_o    (new_value)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [olw_pkg::DATA_W-1:0] left_d, right_d;

    assign cell_ctl[i].op      = op;
    assign cell_ctl[i].is_load = (load_idx == IW'(i));
    assign cell_ctl[i].is_tail = (tail_idx == IW'(i));

    if (i == 0) begin : g_first
      assign left_d = new_value;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    olw_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl[i]),
      .value_i(new_value),
      .left_i (left_d),
      .right_i(right_d),
      .head_i (cell_data[0]),
      .data_o (cell_data[i])
    );
  end

endmodule
